@@ sv/unix_time_to_calendar_assert.svh @@
// Assertion macros for the Unix time to calendar converter.
`ifndef UNIX_TIME_TO_CALENDAR_ASSERT_SVH
`define UNIX_TIME_TO_CALENDAR_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define U2C_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define U2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/u2c_pkg.sv @@
// Shared types, constants and the month length table of the calendar converter.
`timescale 1ns / 1ps

package u2c_pkg;

  localparam int unsigned EpochW = 32;
  localparam int unsigned OffW   = 16;
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonW   = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned DaysW  = 17;
  localparam int unsigned RemW   = 17;
  localparam int unsigned YlenW  = 9;

  localparam logic [OffW-1:0] OffsetReset = 16'd28800;

  // Divisors for the remainder back-multiplies
  localparam logic [RemW-1:0] SecsPerDay  = 17'd86400;
  localparam logic [RemW-1:0] SecsPerHour = 17'd3600;
  localparam logic [SecW-1:0] SecsPerMin  = 6'd60;

  // Reciprocals: x / d equals (x * ceil(2^s / d)) >> s over the whole input range
  // Days: (t >> 7) / 675, 25-bit x, s = 35
  localparam logic [25:0] DayRecip  = 26'd50903317;
  // Hours: (r >> 4) / 225, 13-bit x, s = 21
  localparam logic [13:0] HourRecip = 14'd9321;
  // Minutes: (r >> 2) / 15, 10-bit x, s = 14
  localparam logic [10:0] MinRecip  = 11'd1093;

  localparam logic [YearW-1:0] BaseYear   = 12'd1970;
  localparam logic [6:0]       Mod100Base = 7'd70;
  localparam logic [8:0]       Mod400Base = 9'd370;
  localparam logic [6:0]       Mod100Last = 7'd99;
  localparam logic [8:0]       Mod400Last = 9'd399;

  localparam logic [YlenW-1:0] LeapYearLen   = 9'd366;
  localparam logic [YlenW-1:0] CommonYearLen = 9'd365;

  typedef enum logic [3:0] {
    S_IDLE, S_DAYQ, S_DAYR, S_HOURQ, S_HOURR, S_MINQ, S_MINR, S_YEAR, S_MONTH, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD_IN, OP_QUO, OP_REM, OP_YEAR, OP_MONTH, OP_OUT
  } dp_op_e;

  typedef enum logic [1:0] {
    DIV_DAY, DIV_HOUR, DIV_MIN
  } dsel_e;

  typedef struct packed {
    dp_op_e op;
    dsel_e  dsel;
  } dp_cmd_t;

  typedef struct packed {
    logic year_fits;
    logic month_fits;
  } dp_stat_t;

  // Days in a month, months counted from zero
  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] mon,
                                                input logic leap);
    logic [DayW-1:0] len;
    unique case (mon)
      4'd1:                   len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ sv/u2c_ctrl.sv @@
// Sequencer of the calendar converter: time split, year walk and month walk.
`timescale 1ns / 1ps

module u2c_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  u2c_pkg::dp_stat_t stat_i,
  output u2c_pkg::dp_cmd_t  cmd_o
);

  u2c_pkg::state_e                state_q, state_d;
  logic                           out_valid_q, out_valid_d;

  // State and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= u2c_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = u2c_pkg::OP_NONE;
    cmd_o.dsel = u2c_pkg::DIV_DAY;
    unique case (state_q)
      u2c_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = u2c_pkg::OP_LOAD_IN;
          state_d  = u2c_pkg::S_DAYQ;
        end
      end
      u2c_pkg::S_DAYQ: begin
        cmd_o.op   = u2c_pkg::OP_QUO;
        cmd_o.dsel = u2c_pkg::DIV_DAY;
        state_d    = u2c_pkg::S_DAYR;
      end
      u2c_pkg::S_DAYR: begin
        cmd_o.op   = u2c_pkg::OP_REM;
        cmd_o.dsel = u2c_pkg::DIV_DAY;
        state_d    = u2c_pkg::S_HOURQ;
      end
      u2c_pkg::S_HOURQ: begin
        cmd_o.op   = u2c_pkg::OP_QUO;
        cmd_o.dsel = u2c_pkg::DIV_HOUR;
        state_d    = u2c_pkg::S_HOURR;
      end
      u2c_pkg::S_HOURR: begin
        cmd_o.op   = u2c_pkg::OP_REM;
        cmd_o.dsel = u2c_pkg::DIV_HOUR;
        state_d    = u2c_pkg::S_MINQ;
      end
      u2c_pkg::S_MINQ: begin
        cmd_o.op   = u2c_pkg::OP_QUO;
        cmd_o.dsel = u2c_pkg::DIV_MIN;
        state_d    = u2c_pkg::S_MINR;
      end
      u2c_pkg::S_MINR: begin
        cmd_o.op   = u2c_pkg::OP_REM;
        cmd_o.dsel = u2c_pkg::DIV_MIN;
        state_d    = u2c_pkg::S_YEAR;
      end
      u2c_pkg::S_YEAR: begin
        if (stat_i.year_fits) state_d = u2c_pkg::S_MONTH;
        else                  cmd_o.op = u2c_pkg::OP_YEAR;
      end
      u2c_pkg::S_MONTH: begin
        if (stat_i.month_fits) state_d = u2c_pkg::S_DONE;
        else                   cmd_o.op = u2c_pkg::OP_MONTH;
      end
      u2c_pkg::S_DONE: begin
        // Hold until the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = u2c_pkg::OP_OUT;
          state_d  = u2c_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = u2c_pkg::S_IDLE;
      end
    endcase
  end

  // Set the result flag on load, drop it when the result is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == u2c_pkg::OP_OUT) out_valid_d = 1'b1;
    else if (out_ready_i)            out_valid_d = 1'b0;
  end

  assign in_ready_o  = (state_q == u2c_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ sv/u2c_dp.sv @@
// Datapath of the calendar converter: offset register, time split, year and month walk.
`timescale 1ns / 1ps

module u2c_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [u2c_pkg::OffW-1:0]    cfg_wdata_i,
  input  logic [u2c_pkg::EpochW-1:0]  epoch_seconds_i,
  input  u2c_pkg::dp_cmd_t            cmd_i,
  output u2c_pkg::dp_stat_t           stat_o,
  output logic [u2c_pkg::YearW-1:0]   year_out_o,
  output logic [u2c_pkg::MonW-1:0]    month_out_o,
  output logic [u2c_pkg::DayW-1:0]    day_out_o,
  output logic [u2c_pkg::HourW-1:0]   hour_out_o,
  output logic [u2c_pkg::MinW-1:0]    minute_out_o,
  output logic [u2c_pkg::SecW-1:0]    second_out_o
);

  logic [u2c_pkg::OffW-1:0]   off_q;
  logic [u2c_pkg::EpochW-1:0] t_q;
  logic [u2c_pkg::RemW-1:0]   r_q;
  logic [u2c_pkg::DaysW-1:0]  days_q;
  logic [u2c_pkg::HourW-1:0]  hour_q;
  logic [u2c_pkg::MinW-1:0]   minute_q;
  logic [u2c_pkg::SecW-1:0]   second_q;
  logic [u2c_pkg::YearW-1:0]  year_q;
  logic [6:0]                 m100_q;
  logic [8:0]                 m400_q;
  logic [u2c_pkg::MonW-1:0]   mon_q;

  logic [u2c_pkg::YearW-1:0]  year_res_q;
  logic [u2c_pkg::MonW-1:0]   month_res_q;
  logic [u2c_pkg::DayW-1:0]   day_res_q;
  logic [u2c_pkg::HourW-1:0]  hour_res_q;
  logic [u2c_pkg::MinW-1:0]   minute_res_q;
  logic [u2c_pkg::SecW-1:0]   second_res_q;

  logic [50:0]                day_prod;
  logic [26:0]                hour_prod;
  logic [20:0]                min_prod;
  logic [u2c_pkg::RemW-1:0]   day_back;
  logic [u2c_pkg::RemW-1:0]   hour_back;
  logic [u2c_pkg::SecW-1:0]   min_back;
  logic                       leap;
  logic [u2c_pkg::YlenW-1:0]  ylen;
  logic [u2c_pkg::DayW-1:0]   mlen;
  logic [u2c_pkg::DaysW-1:0]  ylen_ext;
  logic [u2c_pkg::DaysW-1:0]  mlen_ext;

  // Offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= u2c_pkg::OffsetReset;
    end else if (cfg_we_i) begin
      off_q <= cfg_wdata_i;
    end
  end

  // Quotients by reciprocal multiply, after shifting out the power-of-two factor
  assign day_prod  = {26'd0, t_q[31:7]} * {25'd0, u2c_pkg::DayRecip};
  assign hour_prod = {14'd0, r_q[16:4]} * {13'd0, u2c_pkg::HourRecip};
  assign min_prod  = {11'd0, r_q[11:2]} * {10'd0, u2c_pkg::MinRecip};

  // Back-multiplies for the remainders, kept to the width of the remainder each one feeds
  assign day_back  = days_q * u2c_pkg::SecsPerDay;
  assign hour_back = {{(u2c_pkg::RemW-u2c_pkg::HourW){1'b0}}, hour_q} * u2c_pkg::SecsPerHour;
  assign min_back  = minute_q * u2c_pkg::SecsPerMin;

  // Gregorian leap rule from the running year residues
  assign leap     = ((year_q[1:0] == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);
  assign ylen     = leap ? u2c_pkg::LeapYearLen : u2c_pkg::CommonYearLen;
  assign mlen     = u2c_pkg::month_len(mon_q, leap);
  assign ylen_ext = {{(u2c_pkg::DaysW-u2c_pkg::YlenW){1'b0}}, ylen};
  assign mlen_ext = {{(u2c_pkg::DaysW-u2c_pkg::DayW){1'b0}}, mlen};

  assign stat_o.year_fits  = (days_q < ylen_ext);
  assign stat_o.month_fits = (days_q < mlen_ext);

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      u2c_pkg::OP_LOAD_IN: begin
        t_q    <= epoch_seconds_i + {{(u2c_pkg::EpochW-u2c_pkg::OffW){1'b0}}, off_q};
        year_q <= u2c_pkg::BaseYear;
        m100_q <= u2c_pkg::Mod100Base;
        m400_q <= u2c_pkg::Mod400Base;
        mon_q  <= '0;
      end
      u2c_pkg::OP_QUO: begin
        case (cmd_i.dsel)
          u2c_pkg::DIV_DAY:  days_q   <= {1'b0, day_prod[50:35]};
          u2c_pkg::DIV_HOUR: hour_q   <= hour_prod[25:21];
          default:           minute_q <= min_prod[19:14];
        endcase
      end
      u2c_pkg::OP_REM: begin
        case (cmd_i.dsel)
          u2c_pkg::DIV_DAY:  r_q      <= t_q[u2c_pkg::RemW-1:0] - day_back;
          u2c_pkg::DIV_HOUR: r_q      <= r_q - hour_back;
          default:           second_q <= r_q[u2c_pkg::SecW-1:0] - min_back;
        endcase
      end
      u2c_pkg::OP_YEAR: begin
        days_q <= days_q - ylen_ext;
        year_q <= year_q + 1'b1;
        m100_q <= (m100_q == u2c_pkg::Mod100Last) ? 7'd0 : m100_q + 1'b1;
        m400_q <= (m400_q == u2c_pkg::Mod400Last) ? 9'd0 : m400_q + 1'b1;
      end
      u2c_pkg::OP_MONTH: begin
        days_q <= days_q - mlen_ext;
        mon_q  <= mon_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register, loaded once the walk is finished
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == u2c_pkg::OP_OUT) begin
      year_res_q   <= year_q;
      month_res_q  <= mon_q + 1'b1;
      day_res_q    <= days_q[u2c_pkg::DayW-1:0] + 1'b1;
      hour_res_q   <= hour_q;
      minute_res_q <= minute_q;
      second_res_q <= second_q;
    end
  end

  assign year_out_o   = year_res_q;
  assign month_out_o  = month_res_q;
  assign day_out_o    = day_res_q;
  assign hour_out_o   = hour_res_q;
  assign minute_out_o = minute_res_q;
  assign second_out_o = second_res_q;

endmodule

@@ sv/unix_time_to_calendar.sv @@
// Top level of the Unix time to local calendar date and time converter.
// Usage:
//   Input channel in_valid_i/in_ready_o carries one request, epoch_seconds_i.
//   Output channel out_valid_o/out_ready_i returns year, month, day, hour,
//   minute and second of the local time for that request.
//   cfg_we_i writes cfg_wdata_i into the time-zone offset (seconds); write
//   it only while no request is in flight.
// Sequence: after acceptance the timestamp plus the offset is loaded; the
//   states DAYQ, DAYR, HOURQ, HOURR, MINQ and MINR split off days, hours,
//   minutes and seconds by reciprocal multiplies; the year and month walks
//   then take off one year or month length per step until the rest fits.
// Throughput: one request at a time; in_ready_o rises with out_valid_o.
// Reset: clears the sequencer and the result flag and sets the offset to
//   28800 seconds.
// Stall: a result waiting on out_ready_i stays in the output register while
//   the next request is accepted and worked on; that request waits in its
//   last step until the output register is free.
`timescale 1ns / 1ps

module unix_time_to_calendar (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [u2c_pkg::OffW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [u2c_pkg::EpochW-1:0]  epoch_seconds_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [u2c_pkg::YearW-1:0]   year_out_o,
  output logic [u2c_pkg::MonW-1:0]    month_out_o,
  output logic [u2c_pkg::DayW-1:0]    day_out_o,
  output logic [u2c_pkg::HourW-1:0]   hour_out_o,
  output logic [u2c_pkg::MinW-1:0]    minute_out_o,
  output logic [u2c_pkg::SecW-1:0]    second_out_o
);

  u2c_pkg::dp_cmd_t  cmd;
  u2c_pkg::dp_stat_t stat;

  // Sequencer
  u2c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath
  u2c_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .epoch_seconds_i (epoch_seconds_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .year_out_o      (year_out_o),
    .month_out_o     (month_out_o),
    .day_out_o       (day_out_o),
    .hour_out_o      (hour_out_o),
    .minute_out_o    (minute_out_o),
    .second_out_o    (second_out_o)
  );

`include "unix_time_to_calendar_assert.svh"

  `U2C_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "accepted a request while busy")
  `U2C_ASSERT_NOW(a_no_overwrite, cmd.op == u2c_pkg::OP_OUT, !out_valid_o || out_ready_i, "pending result overwritten")
  `U2C_ASSERT_NOW(a_result_range, out_valid_o, (month_out_o >= 4'd1) && (month_out_o <= 4'd12) && (day_out_o != 5'd0) && (hour_out_o <= 5'd23), "result field out of range")

endmodule

@@ bench/unix_time_to_calendar_tb.sv @@
// Self-checking testbench for the Unix time to local calendar converter.
`timescale 1ns / 1ps

module unix_time_to_calendar_tb;

  localparam int unsigned DaySecs   = 86400;
  localparam int unsigned HourSecs  = 3600;
  localparam int unsigned MinSecs   = 60;
  localparam int unsigned FirstYear = 1970;
  localparam int unsigned LastYear  = 2106;
  localparam int unsigned MaxOffset = 65535;
  localparam int unsigned TopOffset = 50400;
  localparam int unsigned DrainWait = 250;
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [u2c_pkg::YearW-1:0] year;
    logic [u2c_pkg::MonW-1:0]  month;
    logic [u2c_pkg::DayW-1:0]  day;
    logic [u2c_pkg::HourW-1:0] hour;
    logic [u2c_pkg::MinW-1:0]  minute;
    logic [u2c_pkg::SecW-1:0]  second;
  } calendar_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [u2c_pkg::OffW-1:0]     cfg_wdata_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [u2c_pkg::EpochW-1:0]   epoch_seconds_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [u2c_pkg::YearW-1:0]    year_out_o;
  logic [u2c_pkg::MonW-1:0]     month_out_o;
  logic [u2c_pkg::DayW-1:0]     day_out_o;
  logic [u2c_pkg::HourW-1:0]    hour_out_o;
  logic [u2c_pkg::MinW-1:0]     minute_out_o;
  logic [u2c_pkg::SecW-1:0]     second_out_o;

  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  function automatic bit is_leap(int unsigned yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  // Shift the timestamp into local time and split it into date and time of day
  function automatic calendar_t to_local_calendar(logic [31:0] epoch, logic [15:0] offset);
    calendar_t   cal;
    logic [31:0] t;
    int unsigned days, rem, yr, mo, ylen, mlen;
    t = epoch + 32'(offset);
    days = t / DaySecs;
    rem = t % DaySecs;
    cal.hour = 5'(rem / HourSecs);
    rem = rem % HourSecs;
    cal.minute = 6'(rem / MinSecs);
    cal.second = 6'(rem % MinSecs);
    // Count off whole years, then whole months
    yr = FirstYear;
    ylen = is_leap(yr) ? 366 : 365;
    while (days >= ylen) begin
      days -= ylen;
      yr++;
      ylen = is_leap(yr) ? 366 : 365;
    end
    for (mo = 0; mo < 11; mo++) begin
      mlen = MonthDays[mo] + ((mo == 1 && is_leap(yr)) ? 1 : 0);
      if (days < mlen) break;
      days -= mlen;
    end
    cal.year = 12'(yr);
    cal.month = 4'(mo + 1);
    cal.day = 5'(days + 1);
    return cal;
  endfunction

  // Seconds from the epoch to the first instant of a month (month counted from zero)
  function automatic longint month_start_secs(int unsigned yr, int unsigned mo);
    longint      d;
    int unsigned y, m;
    d = 0;
    for (y = FirstYear; y < yr; y++) d += is_leap(y) ? 366 : 365;
    for (m = 0; m < mo; m++) d += MonthDays[m] + ((m == 1 && is_leap(yr)) ? 1 : 0);
    return d * DaySecs;
  endfunction

  // Timestamp whose local time is the given local second count
  function automatic logic [31:0] local_to_epoch(longint local_secs, logic [15:0] offset);
    return 32'(local_secs - longint'(offset));
  endfunction

  // Pick a request: half raw random, the rest near year, month and wrap edges
  function automatic logic [31:0] pick_epoch(logic [15:0] offset);
    int unsigned kind, yr, mo;
    int          delta;
    longint      base;
    kind = $urandom_range(0, 9);
    delta = int'($urandom_range(0, 8)) - 4;
    if ($urandom_range(0, 1) != 0) delta += (int'($urandom_range(0, 48)) - 24) * int'(HourSecs);
    if ($urandom_range(0, 1) != 0) yr = FirstYear + 2 + 4 * $urandom_range(0, 33);
    else yr = $urandom_range(FirstYear, LastYear);
    case (kind)
      0, 1, 2, 3, 4: return $urandom();
      5, 6: base = month_start_secs(yr, 0);
      7: begin
        mo = ($urandom_range(0, 1) != 0) ? 2 : $urandom_range(1, 11);
        base = month_start_secs(yr, mo);
      end
      8: return 32'hFFFF_FFFF - $urandom_range(0, 200000);
      default: return $urandom_range(0, 200000);
    endcase
    return local_to_epoch(base + longint'(delta), offset);
  endfunction

  // Hold the offset copy and the dates still owed by the block
  class calendar_checker;
    logic [15:0] offset;
    calendar_t   owed_dates[$];
    int unsigned mismatches;

    function new();
      offset = u2c_pkg::OffsetReset;
      mismatches = 0;
    endfunction

    function void note_request(logic [31:0] epoch);
      owed_dates.push_back(to_local_calendar(epoch, offset));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(calendar_t got);
      calendar_t want;
      if (owed_dates.size() == 0) begin
        $display("%0t: result with no request pending: expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                 $time, got.year, got.month, got.day, got.hour, got.minute, got.second);
        mismatches++;
        return;
      end
      want = owed_dates.pop_front();
      compare_field("year", 32'(want.year), 32'(got.year));
      compare_field("month", 32'(want.month), 32'(got.month));
      compare_field("day", 32'(want.day), 32'(got.day));
      compare_field("hour", 32'(want.hour), 32'(got.hour));
      compare_field("minute", 32'(want.minute), 32'(got.minute));
      compare_field("second", 32'(want.second), 32'(got.second));
    endfunction
  endclass

  calendar_checker dates;

  unix_time_to_calendar u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .epoch_seconds_i (epoch_seconds_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .year_out_o      (year_out_o),
    .month_out_o     (month_out_o),
    .day_out_o       (day_out_o),
    .hour_out_o      (hour_out_o),
    .minute_out_o    (minute_out_o),
    .second_out_o    (second_out_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      dates.check_result(calendar_t'{year_out_o, month_out_o, day_out_o,
                                     hour_out_o, minute_out_o, second_out_o});
    end
  end

  // Issue one request; called and returns at a falling edge
  task automatic send_request(input logic [31:0] epoch);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    epoch_seconds_i <= epoch;
    do @(posedge clk_i); while (!in_ready_o);
    dates.note_request(epoch);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every owed date has come back
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (dates.owed_dates.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_offset(input logic [15:0] offset);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= offset;
    dates.offset = offset;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] offset, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned count);
    drain_requests();
    write_offset(offset);
    send_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (count) send_request(pick_epoch(offset));
  endtask

  initial begin
    logic [31:0] edge_cases[$];
    logic [15:0] off;
    dates = new();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed requests at the reset offset
    off = u2c_pkg::OffsetReset;
    edge_cases.push_back(32'h0000_0000);
    edge_cases.push_back(32'hFFFF_FFFF);
    edge_cases.push_back(32'hFFFF_FFFF - 32'(off));
    edge_cases.push_back(32'hFFFF_FFFF - 32'(off) + 32'd1);
    edge_cases.push_back(32'h7FFF_FFFF);
    edge_cases.push_back(32'h8000_0000);
    edge_cases.push_back(32'hAAAA_AAAA);
    edge_cases.push_back(32'h5555_5555);
    edge_cases.push_back(local_to_epoch(longint'(DaySecs) - 1, off));
    edge_cases.push_back(local_to_epoch(longint'(DaySecs), off));
    edge_cases.push_back(local_to_epoch(month_start_secs(1971, 0) - 1, off));
    edge_cases.push_back(local_to_epoch(month_start_secs(1972, 2) - 1, off));
    edge_cases.push_back(local_to_epoch(month_start_secs(1973, 0) - 1, off));
    edge_cases.push_back(local_to_epoch(month_start_secs(2000, 2) - 1, off));
    edge_cases.push_back(local_to_epoch(month_start_secs(2000, 2), off));
    edge_cases.push_back(local_to_epoch(month_start_secs(2001, 0) - 1, off));
    edge_cases.push_back(local_to_epoch(month_start_secs(2100, 2) - 1, off));
    edge_cases.push_back(local_to_epoch(month_start_secs(2100, 2), off));
    edge_cases.push_back(local_to_epoch(month_start_secs(2104, 2) - 1, off));
    edge_cases.push_back(local_to_epoch(month_start_secs(2106, 1) + 43199, off));
    foreach (edge_cases[k]) send_request(edge_cases[k]);

    // Random phases across offsets, idle and stall patterns
    run_phase(16'd0, 0, 0, 260);
    run_phase(16'(TopOffset), 76, 0, 260);
    run_phase(16'(MaxOffset), 0, 76, 260);
    run_phase(16'($urandom_range(0, MaxOffset)), 13, 13, 90);
    run_phase(16'($urandom_range(0, TopOffset)), 13, 13, 90);
    run_phase(16'(u2c_pkg::OffsetReset), 13, 13, 90);

    drain_requests();
    repeat (DrainWait) @(posedge clk_i);
    if (dates.mismatches == 0 && dates.owed_dates.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/u2c_pkg.sv
sv/u2c_ctrl.sv
sv/u2c_dp.sv
sv/unix_time_to_calendar.sv
bench/unix_time_to_calendar_tb.sv
